// ===== rtl/core/q2e_pkg.sv =====
`timescale 1ns / 1ps

package q2e_pkg;

  // Width of the sine and cosine terms in Q.28 (2 * (a*b + c*d) of Q2.14 values).
  localparam int CW = 34;
  // Width of the CORDIC vector components, with headroom for gain and pre-rotation.
  localparam int VW = 38;
  // Width of a Q.30 angle inside the CORDIC.
  localparam int ZW = 34;
  // Square root: the radicand is at most 2^56, the root at most 2^28.
  localparam int RW = 57;
  localparam int SQW = 58;
  localparam int SQ_TOP = 56;
  localparam int SQ_STEPS = 29;
  localparam int ROOT_W = 29;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Terms that travel beside the square root.
  typedef struct packed {
    logic signed [CW-1:0] sr;
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] sp;
    logic                 clamp;
  } q2e_term_t;

  // Arctangent table: atan(2^-i) * 2^30, truncated.
  function automatic logic [31:0] atan_q30(input int unsigned i);
    case (i)
      0: return 32'd843314856;
      1: return 32'd497837829;
      2: return 32'd263043836;
      3: return 32'd133525158;
      4: return 32'd67021686;
      5: return 32'd33543515;
      6: return 32'd16775850;
      7: return 32'd8388437;
      8: return 32'd4194282;
      9: return 32'd2097149;
      10: return 32'd1048575;
      11: return 32'd524287;
      12: return 32'd262143;
      13: return 32'd131071;
      14: return 32'd65535;
      15: return 32'd32767;
      16: return 32'd16383;
      17: return 32'd8191;
      18: return 32'd4095;
      19: return 32'd2047;
      20: return 32'd1023;
      21: return 32'd511;
      22: return 32'd255;
      23: return 32'd127;
      24: return 32'd63;
      25: return 32'd31;
      26: return 32'd15;
      27: return 32'd7;
      28: return 32'd3;
      29: return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/quaternion_to_euler_unit.sv =====
`timescale 1ns / 1ps

// Channel   Signals                                   Handshake
// input     quat_x_i, quat_y_i, quat_z_i, quat_w_i    start & !busy
// result    roll_angle_o, pitch_angle_o,              result_valid_o, one-cycle strobe
//           yaw_angle_o, pitch_clamped_o
//
// One quaternion is taken every cycle; busy stays low.
// Each result passes through four stages of products and terms, 30 square root stages,
// CORDIC_STEPS + 1 CORDIC stages with the pre-rotation, and the output rounding stage.
// Reset clears only the valid bits; words in flight at reset are dropped.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_to_euler_unit import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               result_valid_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);

  localparam int K = 30 - ANGLE_FRAC_BITS;
  localparam int LATENCY = 4 + 1 + SQ_STEPS + 1 + CORDIC_STEPS + 1;
  localparam longint RND_L = longint'(1) << (K - 1);
  localparam logic signed [ZW:0] RND = (ZW+1)'(RND_L);
  localparam logic signed [ZW:0] PI_LIM = (ZW+1)'((PI_Q30 + RND_L) >>> K);
  localparam logic signed [ZW:0] HPI_LIM = (ZW+1)'((HALF_PI_Q30 + RND_L) >>> K);
  localparam logic signed [CW-1:0] ONE_Q28 = CW'(64'sd1 <<< 28);

  // Round a Q.30 angle half up to output units and limit it.
  function automatic logic signed [ZW:0] round_sat(input logic signed [ZW-1:0] a,
                                                   input logic signed [ZW:0] lim);
    logic signed [ZW:0] r;
    r = ((ZW+1)'(a) + RND) >>> K;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // Stage 1: component products.
  logic v1_q;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q <= quat_w_i * quat_x_i;
    yz_q <= quat_y_i * quat_z_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    wy_q <= quat_w_i * quat_y_i;
    zx_q <= quat_z_i * quat_x_i;
    wz_q <= quat_w_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
  end

  // Stage 2: sine and cosine terms in Q.28, pitch clamp test.
  logic v2_q;
  q2e_term_t t2_d, t2_q;
  logic [27:0] mag2_d, mag2_q;
  logic signed [32:0] s_sr, s_cr, s_sp, s_sy, s_cy;

  always_comb begin
    s_sr = 33'(wx_q) + 33'(yz_q);
    s_cr = 33'(xx_q) + 33'(yy_q);
    s_sp = 33'(wy_q) - 33'(zx_q);
    s_sy = 33'(wz_q) + 33'(xy_q);
    s_cy = 33'(yy_q) + 33'(zz_q);
    t2_d.sr = {s_sr, 1'b0};
    t2_d.cr = ONE_Q28 - {s_cr, 1'b0};
    t2_d.sp = {s_sp, 1'b0};
    t2_d.sy = {s_sy, 1'b0};
    t2_d.cy = ONE_Q28 - {s_cy, 1'b0};
    t2_d.clamp = (t2_d.sp >= ONE_Q28) || (t2_d.sp <= -ONE_Q28);
    mag2_d = t2_d.sp[CW-1] ? 28'(-t2_d.sp) : t2_d.sp[27:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t2_q   <= t2_d;
    mag2_q <= mag2_d;
  end

  // Stage 3: square of the pitch sine term.
  logic v3_q;
  q2e_term_t t3_q;
  logic [55:0] sq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t3_q  <= t2_q;
    sq3_q <= mag2_q * mag2_q;
  end

  // Stage 4: radicand 1 - s^2 in Q.56.
  logic v4_q;
  q2e_term_t t4_q;
  logic [RW-1:0] rad4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t4_q   <= t3_q;
    rad4_q <= (RW'(1) << SQ_TOP) - RW'(sq3_q);
  end

  // Square root, with the other terms carried alongside.
  logic sq_v;
  logic [ROOT_W-1:0] sq_root;
  q2e_term_t sq_t;

  q2e_isqrt #(
    .PW($bits(q2e_term_t))
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v4_q),
    .rad_i  (rad4_q),
    .pay_i  (t4_q),
    .valid_o(sq_v),
    .root_o (sq_root),
    .pay_o  (sq_t)
  );

  // Three CORDIC pipelines side by side.
  logic roll_v, roll_zero, pitch_zero, yaw_zero;
  logic pitch_v_unused, yaw_v_unused;
  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
  logic [1:0] pitch_pay;
  logic yaw_pay_unused, roll_pay_unused;

  q2e_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_v),
    .y_i    (VW'(sq_t.sr)),
    .x_i    (VW'(sq_t.cr)),
    .pay_i  (1'b0),
    .valid_o(roll_v),
    .zero_o (roll_zero),
    .angle_o(roll_z),
    .pay_o  (roll_pay_unused)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS), .PW(2)) u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_v),
    .y_i    (VW'(sq_t.sp)),
    .x_i    ($signed(VW'(sq_root))),
    .pay_i  ({sq_t.clamp, sq_t.sp[CW-1]}),
    .valid_o(pitch_v_unused),
    .zero_o (pitch_zero),
    .angle_o(pitch_z),
    .pay_o  (pitch_pay)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_v),
    .y_i    (VW'(sq_t.sy)),
    .x_i    (VW'(sq_t.cy)),
    .pay_i  (1'b0),
    .valid_o(yaw_v_unused),
    .zero_o (yaw_zero),
    .angle_o(yaw_z),
    .pay_o  (yaw_pay_unused)
  );

  // Output stage: rounding, limits and the saturated pitch.
  logic signed [ZW:0] roll_r, pitch_r, yaw_r;

  always_comb begin
    roll_r  = roll_zero ? '0 : round_sat(roll_z, PI_LIM);
    yaw_r   = yaw_zero ? '0 : round_sat(yaw_z, PI_LIM);
    if (pitch_pay[1]) begin
      pitch_r = pitch_pay[0] ? -HPI_LIM : HPI_LIM;
    end else begin
      pitch_r = pitch_zero ? '0 : round_sat(pitch_z, HPI_LIM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= roll_v;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_angle_o    <= roll_r[15:0];
    pitch_angle_o   <= pitch_r[14:0];
    yaw_angle_o     <= yaw_r[15:0];
    pitch_clamped_o <= pitch_pay[1];
  end

`ifndef SYNTH
  // A saturated pitch is exactly plus or minus the half-pi limit.
  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && pitch_clamped_o |->
      pitch_angle_o == HPI_LIM[14:0] || pitch_angle_o == 15'(-HPI_LIM))
    else $error("clamped pitch is not at the half-pi limit");

  // Every product word leaves as a result after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ##(LATENCY - 1) result_valid_o)
    else $error("result strobe missing after pipeline latency");
`endif

endmodule

// ===== rtl/core/q2e_isqrt.sv =====
`timescale 1ns / 1ps

// Pipelined floor square root, one result bit per stage, with a side word carried along.
module q2e_isqrt import q2e_pkg::*; #(
  parameter int PW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RW-1:0]     rad_i,
  input  logic [PW-1:0]     pay_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [PW-1:0]     pay_o
);

  logic [SQW-1:0] v_q [0:SQ_STEPS];
  logic [SQW-1:0] r_q [0:SQ_STEPS];
  logic [PW-1:0]  p_q [0:SQ_STEPS];
  logic           vld_q [0:SQ_STEPS];

  // Stage zero simply registers the radicand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q[0] <= SQW'(rad_i);
    r_q[0] <= '0;
    p_q[0] <= pay_i;
  end

  // Each stage tries one bit of the root.
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQ_TOP - 2 * j);
    logic [SQW-1:0] trial;
    assign trial = r_q[j] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      p_q[j+1] <= p_q[j];
      if (v_q[j] >= trial) begin
        v_q[j+1] <= v_q[j] - trial;
        r_q[j+1] <= (r_q[j] >> 1) + BIT;
      end else begin
        v_q[j+1] <= v_q[j];
        r_q[j+1] <= r_q[j] >> 1;
      end
    end
  end

  assign valid_o = vld_q[SQ_STEPS];
  assign root_o  = r_q[SQ_STEPS][ROOT_W-1:0];
  assign pay_o   = p_q[SQ_STEPS];

endmodule

// ===== rtl/core/q2e_cordic.sv =====
`timescale 1ns / 1ps

// Pipelined vectoring CORDIC atan2 with a quadrant pre-rotation stage.
module q2e_cordic import q2e_pkg::*; #(
  parameter int STEPS = 16,
  parameter int PW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [VW-1:0] y_i,
  input  logic signed [VW-1:0] x_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output logic                 zero_o,
  output logic signed [ZW-1:0] angle_o,
  output logic [PW-1:0]        pay_o
);

  localparam logic signed [ZW-1:0] HPI = ZW'(HALF_PI_Q30);

  logic signed [VW-1:0] x_q [0:STEPS];
  logic signed [VW-1:0] y_q [0:STEPS];
  logic signed [ZW-1:0] z_q [0:STEPS];
  logic                 zr_q [0:STEPS];
  logic [PW-1:0]        p_q [0:STEPS];
  logic                 vld_q [0:STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  // Turn a vector with negative x by a quarter turn so that x is not negative.
  always_ff @(posedge clk_i) begin
    p_q[0]  <= pay_i;
    zr_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_q[0] <= y_i;
        y_q[0] <= -x_i;
        z_q[0] <= HPI;
      end else begin
        x_q[0] <= -y_i;
        y_q[0] <= x_i;
        z_q[0] <= -HPI;
      end
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      z_q[0] <= '0;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(i));
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      p_q[i+1]  <= p_q[i];
      zr_q[i+1] <= zr_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + ANG;
      end else begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - ANG;
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign zero_o  = zr_q[STEPS];
  assign angle_o = z_q[STEPS];
  assign pay_o   = p_q[STEPS];

endmodule
